@@ src/assert_macros.svh @@
// Assertion macros shared by the tokenizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define OST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define OST_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define OST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/ost_pkg.sv @@
// Types, token codes, character constants and decode functions of the tokenizer.
package ost_pkg;

  localparam int unsigned CharW = 21;
  localparam int unsigned TokW  = 6;

  typedef logic [CharW-1:0] char_t;
  typedef logic [TokW-1:0]  tok_t;

  // Token codes
  localparam tok_t TOK_NONE       = 6'd0;
  localparam tok_t TOK_QUOTE      = 6'd1;
  localparam tok_t TOK_BSLASH     = 6'd2;
  localparam tok_t TOK_LPAREN     = 6'd3;
  localparam tok_t TOK_RPAREN     = 6'd4;
  localparam tok_t TOK_LBRACK     = 6'd5;
  localparam tok_t TOK_RBRACK     = 6'd6;
  localparam tok_t TOK_LBRACE     = 6'd7;
  localparam tok_t TOK_RBRACE     = 6'd8;
  localparam tok_t TOK_SEMI       = 6'd9;
  localparam tok_t TOK_COMMA      = 6'd10;
  localparam tok_t TOK_AT         = 6'd11;
  localparam tok_t TOK_QUEST      = 6'd12;
  localparam tok_t TOK_TILDE      = 6'd13;
  localparam tok_t TOK_EQEQ       = 6'd14;
  localparam tok_t TOK_FATARROW   = 6'd15;
  localparam tok_t TOK_EQ         = 6'd16;
  localparam tok_t TOK_MINUSEQ    = 6'd17;
  localparam tok_t TOK_ARROW      = 6'd18;
  localparam tok_t TOK_MINUS      = 6'd19;
  localparam tok_t TOK_COLON      = 6'd20;
  localparam tok_t TOK_NE         = 6'd21;
  localparam tok_t TOK_BANG       = 6'd22;
  localparam tok_t TOK_PLUSEQ     = 6'd23;
  localparam tok_t TOK_INC        = 6'd24;
  localparam tok_t TOK_PLUS       = 6'd25;
  localparam tok_t TOK_STAREQ     = 6'd26;
  localparam tok_t TOK_STAR       = 6'd27;
  localparam tok_t TOK_SLASHEQ    = 6'd28;
  localparam tok_t TOK_SLASH      = 6'd29;
  localparam tok_t TOK_AMPEQ      = 6'd30;
  localparam tok_t TOK_ANDAND     = 6'd31;
  localparam tok_t TOK_AMP        = 6'd32;
  localparam tok_t TOK_PIPEEQ     = 6'd33;
  localparam tok_t TOK_OROR       = 6'd34;
  localparam tok_t TOK_PIPE       = 6'd35;
  localparam tok_t TOK_CARETEQ    = 6'd36;
  localparam tok_t TOK_CARET      = 6'd37;
  localparam tok_t TOK_PCTEQ      = 6'd38;
  localparam tok_t TOK_PCT        = 6'd39;
  localparam tok_t TOK_ELLIPSIS   = 6'd40;
  localparam tok_t TOK_RANGEEXCL  = 6'd41;
  localparam tok_t TOK_DOTDOT     = 6'd42;
  localparam tok_t TOK_DOT        = 6'd43;
  localparam tok_t TOK_SPACESHIP  = 6'd44;
  localparam tok_t TOK_LE         = 6'd45;
  localparam tok_t TOK_SHLEQ      = 6'd46;
  localparam tok_t TOK_SHL        = 6'd47;
  localparam tok_t TOK_LT         = 6'd48;
  localparam tok_t TOK_GE         = 6'd49;
  localparam tok_t TOK_SHREQ      = 6'd50;
  localparam tok_t TOK_SHR        = 6'd51;
  localparam tok_t TOK_GT         = 6'd52;

  // Character code points
  localparam char_t CH_QUOTE  = 21'h27;
  localparam char_t CH_BSLASH = 21'h5C;
  localparam char_t CH_LPAREN = 21'h28;
  localparam char_t CH_RPAREN = 21'h29;
  localparam char_t CH_LBRACK = 21'h5B;
  localparam char_t CH_RBRACK = 21'h5D;
  localparam char_t CH_LBRACE = 21'h7B;
  localparam char_t CH_RBRACE = 21'h7D;
  localparam char_t CH_SEMI   = 21'h3B;
  localparam char_t CH_COMMA  = 21'h2C;
  localparam char_t CH_AT     = 21'h40;
  localparam char_t CH_QUEST  = 21'h3F;
  localparam char_t CH_TILDE  = 21'h7E;
  localparam char_t CH_COLON  = 21'h3A;
  localparam char_t CH_EQ     = 21'h3D;
  localparam char_t CH_MINUS  = 21'h2D;
  localparam char_t CH_BANG   = 21'h21;
  localparam char_t CH_PLUS   = 21'h2B;
  localparam char_t CH_STAR   = 21'h2A;
  localparam char_t CH_SLASH  = 21'h2F;
  localparam char_t CH_AMP    = 21'h26;
  localparam char_t CH_PIPE   = 21'h7C;
  localparam char_t CH_CARET  = 21'h5E;
  localparam char_t CH_PCT    = 21'h25;
  localparam char_t CH_DOT    = 21'h2E;
  localparam char_t CH_LT     = 21'h3C;
  localparam char_t CH_GT     = 21'h3E;

  // Pending operator prefix, one-hot
  typedef enum logic [17:0] {
    PFX_NONE   = 18'h00001,
    PFX_EQ     = 18'h00002,
    PFX_MINUS  = 18'h00004,
    PFX_BANG   = 18'h00008,
    PFX_PLUS   = 18'h00010,
    PFX_STAR   = 18'h00020,
    PFX_SLASH  = 18'h00040,
    PFX_AMP    = 18'h00080,
    PFX_PIPE   = 18'h00100,
    PFX_CARET  = 18'h00200,
    PFX_PCT    = 18'h00400,
    PFX_DOT    = 18'h00800,
    PFX_DOTDOT = 18'h01000,
    PFX_LT     = 18'h02000,
    PFX_LTEQ   = 18'h04000,
    PFX_LTLT   = 18'h08000,
    PFX_GT     = 18'h10000,
    PFX_GTGT   = 18'h20000
  } pfx_e;

  typedef struct packed {
    tok_t  token_code;
    char_t passed_char;
    logic  run_last;
  } res_t;

  // Results of one decoded character: count 0..2, slot 0 first.
  typedef struct packed {
    logic [1:0]     cnt;
    res_t [1:0]     res;
  } dec_out_t;

  // Token emitted when a pending prefix can no longer grow.
  function automatic tok_t pfx_fallback(pfx_e p);
    tok_t t;
    case (p)
      PFX_EQ:     t = TOK_EQ;
      PFX_MINUS:  t = TOK_MINUS;
      PFX_BANG:   t = TOK_BANG;
      PFX_PLUS:   t = TOK_PLUS;
      PFX_STAR:   t = TOK_STAR;
      PFX_SLASH:  t = TOK_SLASH;
      PFX_AMP:    t = TOK_AMP;
      PFX_PIPE:   t = TOK_PIPE;
      PFX_CARET:  t = TOK_CARET;
      PFX_PCT:    t = TOK_PCT;
      PFX_DOT:    t = TOK_DOT;
      PFX_DOTDOT: t = TOK_DOTDOT;
      PFX_LT:     t = TOK_LT;
      PFX_LTEQ:   t = TOK_LE;
      PFX_LTLT:   t = TOK_SHL;
      PFX_GT:     t = TOK_GT;
      PFX_GTGT:   t = TOK_SHR;
      default:    t = TOK_NONE;
    endcase
    return t;
  endfunction

  // Single-character token for a character seen with nothing pending.
  function automatic tok_t fresh_tok(char_t c);
    tok_t t;
    case (c)
      CH_QUOTE:  t = TOK_QUOTE;
      CH_BSLASH: t = TOK_BSLASH;
      CH_LPAREN: t = TOK_LPAREN;
      CH_RPAREN: t = TOK_RPAREN;
      CH_LBRACK: t = TOK_LBRACK;
      CH_RBRACK: t = TOK_RBRACK;
      CH_LBRACE: t = TOK_LBRACE;
      CH_RBRACE: t = TOK_RBRACE;
      CH_SEMI:   t = TOK_SEMI;
      CH_COMMA:  t = TOK_COMMA;
      CH_AT:     t = TOK_AT;
      CH_QUEST:  t = TOK_QUEST;
      CH_TILDE:  t = TOK_TILDE;
      CH_COLON:  t = TOK_COLON;
      default:   t = TOK_NONE;
    endcase
    return t;
  endfunction

  // Prefix opened by a character seen with nothing pending.
  function automatic pfx_e fresh_pfx(char_t c);
    pfx_e p;
    case (c)
      CH_EQ:    p = PFX_EQ;
      CH_MINUS: p = PFX_MINUS;
      CH_BANG:  p = PFX_BANG;
      CH_PLUS:  p = PFX_PLUS;
      CH_STAR:  p = PFX_STAR;
      CH_SLASH: p = PFX_SLASH;
      CH_AMP:   p = PFX_AMP;
      CH_PIPE:  p = PFX_PIPE;
      CH_CARET: p = PFX_CARET;
      CH_PCT:   p = PFX_PCT;
      CH_DOT:   p = PFX_DOT;
      CH_LT:    p = PFX_LT;
      CH_GT:    p = PFX_GT;
      default:  p = PFX_NONE;
    endcase
    return p;
  endfunction

endpackage

@@ src/ost_decode.sv @@
// Pending-prefix register and single-pass longest-match decode of one character.
module ost_decode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  ost_pkg::char_t     ch_i,
  input  logic               end_of_input_i,
  output ost_pkg::dec_out_t  dec_o
);
  import ost_pkg::*;

  `include "assert_macros.svh"

  pfx_e     pend_q, pend_d;
  tok_t     ext_tok;
  pfx_e     ext_pfx;
  tok_t     fb_tok;
  tok_t     fr_tok;
  pfx_e     fr_pfx;
  tok_t     eoi_tok;
  dec_out_t dec;

  // Try to extend the pending prefix with the incoming character.
  always_comb begin
    ext_tok = TOK_NONE;
    ext_pfx = PFX_NONE;
    case (pend_q)
      PFX_EQ: begin
        if (ch_i == CH_EQ) ext_tok = TOK_EQEQ;
        else if (ch_i == CH_GT) ext_tok = TOK_FATARROW;
      end
      PFX_MINUS: begin
        if (ch_i == CH_EQ) ext_tok = TOK_MINUSEQ;
        else if (ch_i == CH_GT) ext_tok = TOK_ARROW;
      end
      PFX_BANG:  if (ch_i == CH_EQ) ext_tok = TOK_NE;
      PFX_PLUS: begin
        if (ch_i == CH_EQ) ext_tok = TOK_PLUSEQ;
        else if (ch_i == CH_PLUS) ext_tok = TOK_INC;
      end
      PFX_STAR:  if (ch_i == CH_EQ) ext_tok = TOK_STAREQ;
      PFX_SLASH: if (ch_i == CH_EQ) ext_tok = TOK_SLASHEQ;
      PFX_AMP: begin
        if (ch_i == CH_EQ) ext_tok = TOK_AMPEQ;
        else if (ch_i == CH_AMP) ext_tok = TOK_ANDAND;
      end
      PFX_PIPE: begin
        if (ch_i == CH_EQ) ext_tok = TOK_PIPEEQ;
        else if (ch_i == CH_PIPE) ext_tok = TOK_OROR;
      end
      PFX_CARET: if (ch_i == CH_EQ) ext_tok = TOK_CARETEQ;
      PFX_PCT:   if (ch_i == CH_EQ) ext_tok = TOK_PCTEQ;
      PFX_DOT:   if (ch_i == CH_DOT) ext_pfx = PFX_DOTDOT;
      PFX_DOTDOT: begin
        if (ch_i == CH_DOT) ext_tok = TOK_ELLIPSIS;
        else if (ch_i == CH_LT) ext_tok = TOK_RANGEEXCL;
      end
      PFX_LT: begin
        if (ch_i == CH_EQ) ext_pfx = PFX_LTEQ;
        else if (ch_i == CH_LT) ext_pfx = PFX_LTLT;
      end
      PFX_LTEQ:  if (ch_i == CH_GT) ext_tok = TOK_SPACESHIP;
      PFX_LTLT:  if (ch_i == CH_EQ) ext_tok = TOK_SHLEQ;
      PFX_GT: begin
        if (ch_i == CH_EQ) ext_tok = TOK_GE;
        else if (ch_i == CH_GT) ext_pfx = PFX_GTGT;
      end
      PFX_GTGT:  if (ch_i == CH_EQ) ext_tok = TOK_SHREQ;
      default: begin
        ext_tok = TOK_NONE;
        ext_pfx = PFX_NONE;
      end
    endcase
  end

  assign fb_tok = pfx_fallback(pend_q);
  assign fr_tok = fresh_tok(ch_i);
  assign fr_pfx = fresh_pfx(ch_i);

  // Assemble up to two results and the next prefix.
  always_comb begin
    dec    = '0;
    pend_d = PFX_NONE;
    if (fb_tok != TOK_NONE && ext_tok != TOK_NONE) begin
      dec.res[0].token_code = ext_tok;
      dec.cnt               = 2'd1;
    end else if (fb_tok != TOK_NONE && ext_pfx != PFX_NONE) begin
      pend_d = ext_pfx;
    end else begin
      if (fb_tok != TOK_NONE) begin
        dec.res[0].token_code = fb_tok;
        dec.cnt               = 2'd1;
      end
      if (fr_pfx != PFX_NONE) begin
        pend_d = fr_pfx;
      end else begin
        dec.res[dec.cnt[0]].token_code  = fr_tok;
        dec.res[dec.cnt[0]].passed_char = (fr_tok == TOK_NONE) ? ch_i : '0;
        dec.cnt                         = dec.cnt + 2'd1;
      end
    end
    eoi_tok = pfx_fallback(pend_d);
    if (end_of_input_i && eoi_tok != TOK_NONE) begin
      dec.res[dec.cnt[0]].token_code = eoi_tok;
      dec.cnt                        = dec.cnt + 2'd1;
      pend_d                         = PFX_NONE;
    end
    if (dec.cnt != 2'd0) begin
      dec.res[dec.cnt[0] ^ 1'b1].run_last = 1'b1;
    end
  end

  assign dec_o = dec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= PFX_NONE;
    end else if (accept_i) begin
      pend_q <= pend_d;
    end
  end

  `OST_ASSERT_IMPL(a_pend_real, pend_q != PFX_NONE, pfx_fallback(pend_q) != TOK_NONE,
    "pending prefix holds no real operator prefix")
  `OST_ASSERT_NEXT(a_eoi_flush, accept_i && end_of_input_i, pend_q == PFX_NONE,
    "end of input left a prefix pending")

endmodule

@@ src/ost_outbuf.sv @@
// Two-entry result register with skid slot for the second result of a character.
module ost_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  ost_pkg::dec_out_t dec_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ost_pkg::res_t     head_o
);
  import ost_pkg::*;

  `include "assert_macros.svh"

  res_t head_q, head_d;
  res_t tail_q, tail_d;
  logic head_v_q, head_v_d;
  logic tail_v_q, tail_v_d;
  logic pop;

  assign pop    = head_v_q && !out_stall_i;
  assign full_o = tail_v_q || (head_v_q && out_stall_i);

  always_comb begin
    head_d   = head_q;
    tail_d   = tail_q;
    head_v_d = head_v_q;
    tail_v_d = tail_v_q;
    if (pop) begin
      head_d   = tail_q;
      head_v_d = tail_v_q;
      tail_v_d = 1'b0;
    end
    if (push_i && dec_i.cnt != 2'd0) begin
      head_d   = dec_i.res[0];
      head_v_d = 1'b1;
      tail_d   = dec_i.res[1];
      tail_v_d = (dec_i.cnt == 2'd2);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      tail_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      tail_v_q <= tail_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
  end

  assign out_valid_o = head_v_q;
  assign head_o      = head_q;

  `OST_ASSERT(a_tail_behind_head, !tail_v_q || head_v_q, "second slot filled with head empty")
  `OST_ASSERT_NEXT(a_pair_held, push_i && dec_i.cnt == 2'd2, head_v_q && tail_v_q,
    "pair of results not both held")

endmodule

@@ src/operator_symbol_tokenizer_core.sv @@
// Top level of the longest-match operator and punctuation tokenizer.
//
// Input channel: one character per transaction on ch_i with end_of_input_i,
// taken at a rising edge where in_valid_i is high and in_stall_o is low.
// Output channel: token_code_o, passed_char_o and run_last_o, taken at a rising
// edge where out_valid_o is high and out_stall_i is low.
// A character yields zero, one or two result transactions; run_last_o marks
// the final one of a character. Characters that only lengthen an operator
// prefix yield none until the operator completes or breaks.
// A character's first result is registered and appears in the cycle after it
// is taken. Throughput: one character per cycle while the receiver does not
// stall; a character with two results holds the input while the second drains.
// The rate is set by the single pending-prefix register and the two-slot result buffer.
// Reset clears the pending prefix to none and empties the result buffer.
// When the receiver stalls, the current result holds, and the input stalls
// for as long as a result is waiting, whatever the next character would make.
module operator_symbol_tokenizer_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [20:0]            ch_i,
  input  logic                   end_of_input_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [5:0]             token_code_o,
  output logic [20:0]            passed_char_o,
  output logic                   run_last_o
);
  import ost_pkg::*;

  `include "assert_macros.svh"

  logic     accept;
  logic     full;
  dec_out_t dec;
  res_t     head;

  // Take a character only when the result buffer can absorb its results.
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // Decode against the pending prefix and advance it on accept.
  ost_decode u_decode (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .ch_i           (ch_i),
    .end_of_input_i (end_of_input_i),
    .dec_o          (dec)
  );

  // Hold results until the receiver takes them.
  ost_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .dec_i       (dec),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign token_code_o  = head.token_code;
  assign passed_char_o = head.passed_char;
  assign run_last_o    = head.run_last;

  `OST_ASSERT_IMPL(a_pass_only_nonsym, out_valid_o && token_code_o != TOK_NONE,
    passed_char_o == '0, "symbol token carries a passed character")

endmodule

@@ bench/operator_symbol_tokenizer_core_tb.sv @@
// Self-checking testbench for the longest-match operator tokenizer core.
module operator_symbol_tokenizer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ost_pkg::*;

  localparam int RandomChars = 1600;
  localparam int LongHold    = 60;
  localparam int CycleLimit  = 400000;
  localparam int NumForms    = 52;

  // Every token as it is spelled, in token-code order (entry k is code k+1).
  string op_forms [NumForms] = '{
    "'", "\\", "(", ")", "[", "]", "{", "}", ";", ",", "@", "?", "~",
    "==", "=>", "=", "-=", "->", "-", ":", "!=", "!",
    "+=", "++", "+", "*=", "*", "/=", "/", "&=", "&&", "&",
    "|=", "||", "|", "^=", "^", "%=", "%", "...", "..<", "..",
    ".", "<=>", "<=", "<<=", "<<", "<", ">=", ">>=", ">>", ">"
  };

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid_i     = 1'b0;
  logic        in_stall_o;
  char_t       ch_i           = '0;
  logic        end_of_input_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i    = 1'b0;
  tok_t        token_code_o;
  char_t       passed_char_o;
  logic        run_last_o;

  // Tokenizer shadow state and the tokens still owed by the block.
  pfx_e        pending = PFX_NONE;
  res_t        expected_tokens [$];
  res_t        oldest;
  int          errors      = 0;
  int          cycles      = 0;
  int          chars_sent  = 0;
  int          rx_wait     = 0;
  logic        tx_idle     = 1'b1;
  logic        rx_idle     = 1'b1;
  logic        hold_on     = 1'b0;
  event        hold_go;

  operator_symbol_tokenizer_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .ch_i           (ch_i),
    .end_of_input_i (end_of_input_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .token_code_o   (token_code_o),
    .passed_char_o  (passed_char_o),
    .run_last_o     (run_last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("operator_symbol_tokenizer_core_tb failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Token prediction
  // ---------------------------------------------------------------------------

  // Token that a pending prefix stands for when it cannot grow any further.
  function automatic tok_t prefix_token(pfx_e p);
    case (p)
      PFX_EQ:     return TOK_EQ;
      PFX_MINUS:  return TOK_MINUS;
      PFX_BANG:   return TOK_BANG;
      PFX_PLUS:   return TOK_PLUS;
      PFX_STAR:   return TOK_STAR;
      PFX_SLASH:  return TOK_SLASH;
      PFX_AMP:    return TOK_AMP;
      PFX_PIPE:   return TOK_PIPE;
      PFX_CARET:  return TOK_CARET;
      PFX_PCT:    return TOK_PCT;
      PFX_DOT:    return TOK_DOT;
      PFX_DOTDOT: return TOK_DOTDOT;
      PFX_LT:     return TOK_LT;
      PFX_LTEQ:   return TOK_LE;
      PFX_LTLT:   return TOK_SHL;
      PFX_GT:     return TOK_GT;
      PFX_GTGT:   return TOK_SHR;
      default:    return TOK_NONE;
    endcase
  endfunction

  // Try to lengthen prefix p by c: either a finished token or a longer prefix.
  function automatic void extend_prefix(input pfx_e p, input char_t c,
                                        output tok_t done, output pfx_e grown);
    done  = TOK_NONE;
    grown = PFX_NONE;
    case (p)
      PFX_EQ: begin
        if (c == CH_EQ) done = TOK_EQEQ;
        else if (c == CH_GT) done = TOK_FATARROW;
      end
      PFX_MINUS: begin
        if (c == CH_EQ) done = TOK_MINUSEQ;
        else if (c == CH_GT) done = TOK_ARROW;
      end
      PFX_BANG:  if (c == CH_EQ) done = TOK_NE;
      PFX_PLUS: begin
        if (c == CH_EQ) done = TOK_PLUSEQ;
        else if (c == CH_PLUS) done = TOK_INC;
      end
      PFX_STAR:  if (c == CH_EQ) done = TOK_STAREQ;
      PFX_SLASH: if (c == CH_EQ) done = TOK_SLASHEQ;
      PFX_AMP: begin
        if (c == CH_EQ) done = TOK_AMPEQ;
        else if (c == CH_AMP) done = TOK_ANDAND;
      end
      PFX_PIPE: begin
        if (c == CH_EQ) done = TOK_PIPEEQ;
        else if (c == CH_PIPE) done = TOK_OROR;
      end
      PFX_CARET: if (c == CH_EQ) done = TOK_CARETEQ;
      PFX_PCT:   if (c == CH_EQ) done = TOK_PCTEQ;
      PFX_DOT:   if (c == CH_DOT) grown = PFX_DOTDOT;
      PFX_DOTDOT: begin
        if (c == CH_DOT) done = TOK_ELLIPSIS;
        else if (c == CH_LT) done = TOK_RANGEEXCL;
      end
      PFX_LT: begin
        if (c == CH_EQ) grown = PFX_LTEQ;
        else if (c == CH_LT) grown = PFX_LTLT;
      end
      PFX_LTEQ:  if (c == CH_GT) done = TOK_SPACESHIP;
      PFX_LTLT:  if (c == CH_EQ) done = TOK_SHLEQ;
      PFX_GT: begin
        if (c == CH_EQ) done = TOK_GE;
        else if (c == CH_GT) grown = PFX_GTGT;
      end
      PFX_GTGT:  if (c == CH_EQ) done = TOK_SHREQ;
      default: ;
    endcase
  endfunction

  // Handle c with nothing pending: a one-character token, or a prefix start.
  function automatic void open_token(input char_t c, output tok_t single,
                                     output pfx_e opened);
    single = TOK_NONE;
    opened = PFX_NONE;
    case (c)
      CH_QUOTE:  single = TOK_QUOTE;
      CH_BSLASH: single = TOK_BSLASH;
      CH_LPAREN: single = TOK_LPAREN;
      CH_RPAREN: single = TOK_RPAREN;
      CH_LBRACK: single = TOK_LBRACK;
      CH_RBRACK: single = TOK_RBRACK;
      CH_LBRACE: single = TOK_LBRACE;
      CH_RBRACE: single = TOK_RBRACE;
      CH_SEMI:   single = TOK_SEMI;
      CH_COMMA:  single = TOK_COMMA;
      CH_AT:     single = TOK_AT;
      CH_QUEST:  single = TOK_QUEST;
      CH_TILDE:  single = TOK_TILDE;
      CH_COLON:  single = TOK_COLON;
      CH_EQ:     opened = PFX_EQ;
      CH_MINUS:  opened = PFX_MINUS;
      CH_BANG:   opened = PFX_BANG;
      CH_PLUS:   opened = PFX_PLUS;
      CH_STAR:   opened = PFX_STAR;
      CH_SLASH:  opened = PFX_SLASH;
      CH_AMP:    opened = PFX_AMP;
      CH_PIPE:   opened = PFX_PIPE;
      CH_CARET:  opened = PFX_CARET;
      CH_PCT:    opened = PFX_PCT;
      CH_DOT:    opened = PFX_DOT;
      CH_LT:     opened = PFX_LT;
      CH_GT:     opened = PFX_GT;
      default: ;
    endcase
  endfunction

  // Advance the shadow tokenizer by one accepted character and queue the
  // tokens it owes, the last one flagged.
  function automatic void predict_tokens(char_t c, logic eoi);
    res_t made [$];
    tok_t done;
    pfx_e grown;
    logic taken;
    taken = 1'b0;
    if (pending != PFX_NONE) begin
      extend_prefix(pending, c, done, grown);
      if (done != TOK_NONE) begin
        made.push_back('{token_code: done, passed_char: '0, run_last: 1'b0});
        pending = PFX_NONE;
        taken   = 1'b1;
      end else if (grown != PFX_NONE) begin
        pending = grown;
        taken   = 1'b1;
      end else begin
        // Prefix broken: emit it, then treat c as if nothing were pending.
        made.push_back('{token_code: prefix_token(pending), passed_char: '0,
                         run_last: 1'b0});
        pending = PFX_NONE;
      end
    end
    if (!taken) begin
      open_token(c, done, grown);
      if (grown != PFX_NONE) begin
        pending = grown;
      end else begin
        // Non-symbols pass the character through with code none.
        made.push_back('{token_code: done,
                         passed_char: (done == TOK_NONE) ? c : '0,
                         run_last: 1'b0});
      end
    end
    if (eoi && pending != PFX_NONE) begin
      made.push_back('{token_code: prefix_token(pending), passed_char: '0,
                       run_last: 1'b0});
      pending = PFX_NONE;
    end
    if (made.size() > 0) made[made.size()-1].run_last = 1'b1;
    foreach (made[i]) expected_tokens.push_back(made[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking and receiver stalls
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_tokens.size() == 0) begin
        $display("%0t: unexpected token: expected none, actual code %0d char %h last %b",
                 $time, token_code_o, passed_char_o, run_last_o);
        errors++;
      end else begin
        oldest = expected_tokens.pop_front();
        if (token_code_o !== oldest.token_code) begin
          $display("%0t: token_code expected %0d actual %0d",
                   $time, oldest.token_code, token_code_o);
          errors++;
        end
        if (passed_char_o !== oldest.passed_char) begin
          $display("%0t: passed_char expected %h actual %h",
                   $time, oldest.passed_char, passed_char_o);
          errors++;
        end
        if (run_last_o !== oldest.run_last) begin
          $display("%0t: run_last expected %b actual %b",
                   $time, oldest.run_last, run_last_o);
          errors++;
        end
      end
    end
  end

  // Draw a fresh wait for every taken result; hold stall while it runs out.
  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) rx_wait = rx_idle ? $urandom_range(0, 9) : 0;
    else if (rx_wait > 0) rx_wait--;
    out_stall_i <= hold_on || (rx_wait > 0);
  end

  // Long receiver hold-off, counted here so the sender keeps pushing meanwhile.
  initial begin
    forever begin
      @(hold_go);
      hold_on <= 1'b1;
      repeat (LongHold) @(posedge clk_i);
      hold_on <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Offer one character, after a random gap if tx_idle is set; predict once it is taken.
  // Valid stays high across back-to-back transactions.
  task automatic send_char(input char_t c, input logic eoi);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    ch_i           <= c;
    end_of_input_i <= eoi;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_tokens(c, eoi);
    chars_sent++;
  endtask

  // Spell out one token form; end of input is likelier on its last character than on the others.
  task automatic send_form(input int k);
    logic [7:0] b;
    logic eoi;
    for (int i = 0; i < op_forms[k].len(); i++) begin
      b = op_forms[k][i];
      if (i == op_forms[k].len() - 1) eoi = ($urandom_range(0, 7) == 0);
      else eoi = ($urandom_range(0, 39) == 0);
      send_char(char_t'(b), eoi);
    end
  endtask

  // Drop valid and hold the sender until every owed token has come out.
  task automatic wait_for_tokens();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_tokens.size() != 0) @(posedge clk_i);
  endtask

  // Extremes of the character field, single symbols, prefix growth,
  // broken prefixes and end-of-input flushes.
  task automatic test_directed_forms();
    send_char('0, 1'b1);
    send_char('1, 1'b0);
    send_char(21'h110000, 1'b0);
    send_char(21'h61, 1'b1);
    send_char(CH_LPAREN, 1'b0);
    send_char(CH_COLON, 1'b1);
    send_char(CH_LT, 1'b0);
    send_char(CH_EQ, 1'b0);
    send_char(CH_GT, 1'b0);
    send_char(CH_GT, 1'b0);
    send_char(CH_GT, 1'b0);
    send_char(CH_EQ, 1'b0);
    send_char(CH_DOT, 1'b0);
    send_char(CH_DOT, 1'b0);
    send_char(CH_LT, 1'b0);
    send_char(CH_EQ, 1'b0);
    send_char(21'h61, 1'b0);
    send_char(CH_MINUS, 1'b0);
    send_char(CH_MINUS, 1'b0);
    send_char(CH_LT, 1'b0);
    send_char(CH_LT, 1'b1);
    send_char(CH_DOT, 1'b1);
    wait_for_tokens();
  endtask

  // Hold the receiver off while the sender streams at full rate, so the
  // result buffer fills and the input stalls; then let it drain.
  task automatic test_backpressure();
    logic saved;
    saved   = tx_idle;
    tx_idle = 1'b0;
    -> hold_go;
    repeat (20) send_form($urandom_range(0, NumForms - 1));
    wait_for_tokens();
    tx_idle = saved;
  endtask

  // Mostly well-formed tokens with random content, plus stray symbol
  // characters and noise; idle patterns change every stretch.
  task automatic test_random_stream();
    int stop_at;
    int next_mode;
    int kind;
    logic [7:0] b;
    stop_at   = chars_sent + RandomChars;
    next_mode = chars_sent;
    while (chars_sent < stop_at) begin
      if (chars_sent >= next_mode) begin
        {rx_idle, tx_idle} = 2'($urandom_range(0, 3));
        next_mode = chars_sent + $urandom_range(100, 250);
        if ($urandom_range(0, 2) == 0) wait_for_tokens();
      end
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        send_form($urandom_range(0, NumForms - 1));
      end else if (kind < 80) begin
        b = op_forms[$urandom_range(0, NumForms - 1)][0];
        send_char(char_t'(b), $urandom_range(0, 9) == 0);
      end else if (kind < 90) begin
        send_char(char_t'($urandom_range(32'h20, 32'h7F)), $urandom_range(0, 9) == 0);
      end else begin
        send_char(char_t'($urandom()), $urandom_range(0, 9) == 0);
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_forms();
    test_backpressure();
    test_random_stream();
    wait_for_tokens();
    // Give a stray extra result a chance to show up.
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("operator_symbol_tokenizer_core_tb passed");
    end else begin
      $display("operator_symbol_tokenizer_core_tb failed");
    end
    $finish;
  end

endmodule
